FILE: sv/d8fa_pkg.sv
// Shared types and constants for the D8 flow accumulation block.
// Used by d8fa_ctrl, d8fa_dpath and d8_flow_accumulation; depends on nothing.
package d8fa_pkg;

  localparam int unsigned ACC_W = 13;
  localparam logic [ACC_W-1:0] ACC_MAX = 13'd8191;

  // item modes
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // result kinds
  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_NULL = 2'd2;

  typedef enum logic [4:0] {
    ST_RST_CLR,
    ST_IDLE,
    ST_READ,
    ST_RUN_CLR,
    ST_M_SELF,
    ST_M_SELFW,
    ST_M_NB,
    ST_M_NBW,
    ST_M_WR,
    ST_S_RD,
    ST_S_CHK,
    ST_T_WR,
    ST_T_DIR,
    ST_T_NEXT,
    ST_T_SUM,
    ST_T_SUMW,
    ST_T_STEP,
    ST_T_END,
    ST_DONE
  } state_e;

  // direction memory read address select
  typedef enum logic [1:0] {
    DSEL_SCAN,
    DSEL_NB_SCAN,
    DSEL_TRACE,
    DSEL_MOVE
  } dsel_e;

  typedef struct packed {
    logic  clr_start;
    logic  clr_step;
    logic  load_wr;
    logic  out_read;
    logic  out_run;
    logic  scan_reset;
    logic  scan_adv;
    logic  self_cap;
    logic  nb_clear;
    logic  nb_eval;
    logic  mask_wr;
    logic  t_start;
    logic  t_write;
    logic  t_move;
    logic  t_next;
    logic  sum_add;
    logic  k_adv;
    logic  t_step;
    dsel_e dsel;
    logic  msel_move;
    logic  asel_nb;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic k_last;
    logic mask_bit;
    logic trace_go;
    logic move_ok;
    logic next_stop;
    logic acc_zero;
    logic step_limit;
    logic out_busy;
  } sts_t;

endpackage

FILE: sv/d8_flow_accumulation.sv
// D8 flow accumulation over a raster of up to MAX_ROWS x MAX_COLS cells. Load
// words write a cell's direction code; read words return a cell's total. A run
// word first sweeps the accumulation memory clean (the same sweep runs once
// after reset before any word is accepted), then builds upstream masks for each
// cell in use, then scans the cells in use, and each trace step reads every
// upstream neighbor; every memory has a single read port. One result word ends
// a run.
// Depends on d8fa_pkg, d8fa_ctrl and d8fa_dpath.
module d8_flow_accumulation #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // cell_row[5:0], cell_col[11:6], direction[19:12]
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // accumulation[12:0]
  output logic        m_axis_tuser   // result_kind[0]
);
  import d8fa_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [ACC_W-1:0] out_acc;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {3'b000, out_acc};

  d8fa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  d8fa_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_row_i    (s_axis_tdata[5:0]),
    .in_col_i    (s_axis_tdata[11:6]),
    .in_dir_i    (s_axis_tdata[19:12]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_acc_o   (out_acc),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

FILE: sv/d8fa_ctrl.sv
// Sequencer for the D8 flow accumulation block: item handshake and run phases.
// Depends on d8fa_pkg; drives d8fa_dpath through cmd_t, watches sts_t.
module d8fa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     in_mode_i,
  output logic           in_ready_o,
  output d8fa_pkg::cmd_t cmd_o,
  input  d8fa_pkg::sts_t sts_i
);
  import d8fa_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE) && !sts_i.out_busy;
  assign accept     = in_valid_i && in_ready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RST_CLR: if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (in_mode_i)
            MODE_RUN:  state_d = ST_RUN_CLR;
            MODE_READ: state_d = ST_READ;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:    state_d = ST_IDLE;
      ST_RUN_CLR: if (sts_i.clr_last) state_d = ST_M_SELF;
      ST_M_SELF:  state_d = ST_M_SELFW;
      ST_M_SELFW: state_d = ST_M_NB;
      ST_M_NB:    state_d = ST_M_NBW;
      ST_M_NBW:   state_d = sts_i.k_last ? ST_M_WR : ST_M_NB;
      ST_M_WR:    state_d = sts_i.scan_last ? ST_S_RD : ST_M_SELF;
      ST_S_RD:    state_d = ST_S_CHK;
      ST_S_CHK: begin
        if (sts_i.trace_go)       state_d = ST_T_WR;
        else if (sts_i.scan_last) state_d = ST_DONE;
        else                      state_d = ST_S_RD;
      end
      ST_T_WR:   state_d = ST_T_DIR;
      ST_T_DIR:  state_d = sts_i.move_ok ? ST_T_NEXT : ST_T_END;
      ST_T_NEXT: state_d = sts_i.next_stop ? ST_T_END : ST_T_SUM;
      ST_T_SUM: begin
        if (sts_i.mask_bit)    state_d = ST_T_SUMW;
        else if (sts_i.k_last) state_d = ST_T_STEP;
        else                   state_d = ST_T_SUM;
      end
      ST_T_SUMW: begin
        if (sts_i.acc_zero)    state_d = ST_T_END;
        else if (sts_i.k_last) state_d = ST_T_STEP;
        else                   state_d = ST_T_SUM;
      end
      ST_T_STEP: state_d = sts_i.step_limit ? ST_T_END : ST_T_WR;
      ST_T_END:  state_d = sts_i.scan_last ? ST_DONE : ST_S_RD;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.dsel = DSEL_SCAN;
    case (state_q)
      ST_RST_CLR: cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        if (accept) begin
          case (in_mode_i)
            MODE_LOAD: cmd_o.load_wr = 1'b1;
            MODE_RUN: begin
              cmd_o.clr_start  = 1'b1;
              cmd_o.scan_reset = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_READ:    cmd_o.out_read = 1'b1;
      ST_RUN_CLR: cmd_o.clr_step = 1'b1;
      ST_M_SELF:  cmd_o.dsel = DSEL_SCAN;
      ST_M_SELFW: begin
        cmd_o.self_cap = 1'b1;
        cmd_o.nb_clear = 1'b1;
      end
      ST_M_NB:  cmd_o.dsel = DSEL_NB_SCAN;
      ST_M_NBW: cmd_o.nb_eval = 1'b1;
      ST_M_WR: begin
        cmd_o.mask_wr = 1'b1;
        if (sts_i.scan_last) cmd_o.scan_reset = 1'b1;
        else                 cmd_o.scan_adv   = 1'b1;
      end
      ST_S_RD: cmd_o.dsel = DSEL_SCAN;
      ST_S_CHK: begin
        if (sts_i.trace_go)        cmd_o.t_start  = 1'b1;
        else if (!sts_i.scan_last) cmd_o.scan_adv = 1'b1;
      end
      ST_T_WR: begin
        cmd_o.t_write = 1'b1;
        cmd_o.dsel    = DSEL_TRACE;
      end
      ST_T_DIR: begin
        cmd_o.dsel      = DSEL_MOVE;
        cmd_o.msel_move = 1'b1;
        cmd_o.t_move    = sts_i.move_ok;
      end
      ST_T_NEXT: cmd_o.t_next = !sts_i.next_stop;
      ST_T_SUM: begin
        cmd_o.asel_nb = 1'b1;
        cmd_o.k_adv   = !sts_i.mask_bit;
      end
      ST_T_SUMW: begin
        cmd_o.sum_add = !sts_i.acc_zero;
        cmd_o.k_adv   = !sts_i.acc_zero;
      end
      ST_T_STEP: cmd_o.t_step = 1'b1;
      ST_T_END:  cmd_o.scan_adv = !sts_i.scan_last;
      ST_DONE:   cmd_o.out_run = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: sv/d8fa_dpath.sv
// Datapath of the D8 flow accumulation block: config registers, the three
// cell memories, scan/trace position registers and output word register.
// Depends on d8fa_pkg; commanded by d8fa_ctrl.
module d8fa_dpath #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [7:0]               cfg_data_i,
  // input item
  input  logic [5:0]               in_row_i,
  input  logic [5:0]               in_col_i,
  input  logic [7:0]               in_dir_i,
  // result word
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     out_kind_o,
  output logic [d8fa_pkg::ACC_W-1:0] out_acc_o,
  // control
  input  d8fa_pkg::cmd_t           cmd_i,
  output d8fa_pkg::sts_t           sts_o
);
  import d8fa_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(CELLS + 1);

  // row/col to cell address
  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    return AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  // neighbor k of (r,c): {in bounds, row, col}
  function automatic logic [RW+CW:0] nb_of(input logic [RW-1:0] r,
                                           input logic [CW-1:0] c,
                                           input logic [2:0]    k,
                                           input logic [RW:0]   nr,
                                           input logic [CW:0]   nc);
    logic [1:0]          dr;
    logic [1:0]          dc;
    logic signed [RW+1:0] rr;
    logic signed [CW+1:0] cc;
    logic                ok;
    case (k)
      3'd0:    begin dr = 2'b00; dc = 2'b01; end // E
      3'd1:    begin dr = 2'b01; dc = 2'b01; end // SE
      3'd2:    begin dr = 2'b01; dc = 2'b00; end // S
      3'd3:    begin dr = 2'b01; dc = 2'b11; end // SW
      3'd4:    begin dr = 2'b00; dc = 2'b11; end // W
      3'd5:    begin dr = 2'b11; dc = 2'b11; end // NW
      3'd6:    begin dr = 2'b11; dc = 2'b00; end // N
      default: begin dr = 2'b11; dc = 2'b01; end // NE
    endcase
    rr = $signed({2'b00, r}) + $signed({{RW{dr[1]}}, dr});
    cc = $signed({2'b00, c}) + $signed({{CW{dc[1]}}, dc});
    ok = !rr[RW+1] && (rr[RW:0] < nr) && !cc[CW+1] && (cc[CW:0] < nc);
    return {ok, rr[RW-1:0], cc[CW-1:0]};
  endfunction

  // configuration registers
  logic [6:0] rows_cfg_q, cols_cfg_q;
  logic [7:0] null_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= 7'd64;
      cols_cfg_q <= 7'd64;
      null_q     <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROWS: rows_cfg_q <= cfg_data_i[6:0];
        CFG_COLS: cols_cfg_q <= cfg_data_i[6:0];
        CFG_NULL: null_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // dimensions in use, clamped into range
  logic [RW:0]   rows_eff;
  logic [CW:0]   cols_eff;
  logic [SW-1:0] step_lim;

  always_comb begin
    if (rows_cfg_q == 7'd0)             rows_eff = (RW+1)'(1);
    else if (int'(rows_cfg_q) > MAX_ROWS) rows_eff = (RW+1)'(MAX_ROWS);
    else                                 rows_eff = (RW+1)'(rows_cfg_q);
    if (cols_cfg_q == 7'd0)             cols_eff = (CW+1)'(1);
    else if (int'(cols_cfg_q) > MAX_COLS) cols_eff = (CW+1)'(MAX_COLS);
    else                                 cols_eff = (CW+1)'(cols_cfg_q);
  end

  assign step_lim = SW'(rows_eff) * SW'(cols_eff);

  // input cell address
  logic          in_inside;
  logic [AW-1:0] in_addr;
  assign in_inside = (int'(in_row_i) < MAX_ROWS) && (int'(in_col_i) < MAX_COLS);
  assign in_addr   = cell_addr(RW'(in_row_i), CW'(in_col_i));

  // sequencing registers
  logic [AW-1:0]    clr_q;
  logic [RW-1:0]    scan_r_q, t_r_q;
  logic [CW-1:0]    scan_c_q, t_c_q;
  logic [2:0]       k_q;
  logic [7:0]       mask_q, self_q;
  logic [ACC_W-1:0] sum_q;
  logic [SW-1:0]    steps_q;
  logic             in_inside_q;

  // memory read data
  logic [7:0]       dir_rd_q, mask_rd_q;
  logic [ACC_W-1:0] acc_rd_q;

  // neighbor positions
  logic          nbs_ok, nbt_ok, mv_ok;
  logic [RW-1:0] nbs_r, nbt_r, mv_r;
  logic [CW-1:0] nbs_c, nbt_c, mv_c;
  logic [2:0]    mv_k;
  logic          mv_onehot;
  logic [2:0]    want_k;
  logic [7:0]    want_code;

  always_comb begin
    mv_k = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (dir_rd_q[i]) mv_k = 3'(i);
    end
  end

  assign mv_onehot = $onehot(dir_rd_q);
  assign {nbs_ok, nbs_r, nbs_c} = nb_of(scan_r_q, scan_c_q, k_q, rows_eff, cols_eff);
  assign {nbt_ok, nbt_r, nbt_c} = nb_of(t_r_q, t_c_q, k_q, rows_eff, cols_eff);
  assign {mv_ok, mv_r, mv_c}    = nb_of(t_r_q, t_c_q, mv_k, rows_eff, cols_eff);
  assign want_k    = k_q + 3'd4;
  assign want_code = 8'b1 << want_k;

  // saturating adds
  logic [ACC_W:0]   inc_w, add_w;
  logic [ACC_W-1:0] acc_wval, sum_next;
  assign inc_w    = {1'b0, sum_q} + 1'b1;
  assign acc_wval = inc_w[ACC_W] ? ACC_MAX : inc_w[ACC_W-1:0];
  assign add_w    = {1'b0, sum_q} + {1'b0, acc_rd_q};
  assign sum_next = add_w[ACC_W] ? ACC_MAX : add_w[ACC_W-1:0];

  // status
  logic scan_last;
  assign scan_last = (scan_r_q == RW'(rows_eff - 1'b1)) &&
                     (scan_c_q == CW'(cols_eff - 1'b1));

  assign sts_o.clr_last   = (clr_q == AW'(CELLS - 1));
  assign sts_o.scan_last  = scan_last;
  assign sts_o.k_last     = (k_q == 3'd7);
  assign sts_o.mask_bit   = mask_q[k_q] && nbt_ok;
  assign sts_o.trace_go   = (dir_rd_q != null_q) && (mask_rd_q == 8'd0);
  assign sts_o.move_ok    = mv_onehot && mv_ok;
  assign sts_o.next_stop  = (dir_rd_q == null_q) || (mask_rd_q == 8'd0);
  assign sts_o.acc_zero   = (acc_rd_q == '0);
  assign sts_o.step_limit = ((steps_q + 1'b1) >= step_lim);
  assign sts_o.out_busy   = out_valid_o;

  // read address selection
  logic [AW-1:0] dir_raddr, mask_raddr, acc_raddr, scan_addr, t_addr, mv_addr;
  assign scan_addr = cell_addr(scan_r_q, scan_c_q);
  assign t_addr    = cell_addr(t_r_q, t_c_q);
  assign mv_addr   = cell_addr(mv_r, mv_c);

  always_comb begin
    case (cmd_i.dsel)
      DSEL_SCAN:    dir_raddr = scan_addr;
      DSEL_NB_SCAN: dir_raddr = cell_addr(nbs_r, nbs_c);
      DSEL_TRACE:   dir_raddr = t_addr;
      DSEL_MOVE:    dir_raddr = mv_addr;
      default:      dir_raddr = scan_addr;
    endcase
  end

  assign mask_raddr = cmd_i.msel_move ? mv_addr : scan_addr;
  assign acc_raddr  = cmd_i.asel_nb ? cell_addr(nbt_r, nbt_c) : in_addr;

  // cell memories
  logic [7:0]       dir_mem  [CELLS];
  logic [7:0]       mask_mem [CELLS];
  logic [ACC_W-1:0] acc_mem  [CELLS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && in_inside) dir_mem[in_addr] <= in_dir_i;
    dir_rd_q <= dir_mem[dir_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mask_wr) mask_mem[scan_addr] <= (self_q != null_q) ? mask_q : 8'd0;
    mask_rd_q <= mask_mem[mask_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step)     acc_mem[clr_q]  <= '0;
    else if (cmd_i.t_write) acc_mem[t_addr] <= acc_wval;
    acc_rd_q <= acc_mem[acc_raddr];
  end

  // clear sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_start) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // scan position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_r_q <= '0;
      scan_c_q <= '0;
    end else if (cmd_i.scan_reset) begin
      scan_r_q <= '0;
      scan_c_q <= '0;
    end else if (cmd_i.scan_adv) begin
      if (scan_c_q == CW'(cols_eff - 1'b1)) begin
        scan_c_q <= '0;
        scan_r_q <= scan_r_q + 1'b1;
      end else begin
        scan_c_q <= scan_c_q + 1'b1;
      end
    end
  end

  // trace state: position, neighbor index, masks, running sum, step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_r_q   <= '0;
      t_c_q   <= '0;
      k_q     <= '0;
      mask_q  <= '0;
      self_q  <= '0;
      sum_q   <= '0;
      steps_q <= '0;
    end else begin
      if (cmd_i.self_cap) self_q <= dir_rd_q;
      if (cmd_i.nb_clear) begin
        k_q    <= '0;
        mask_q <= '0;
      end
      if (cmd_i.nb_eval) begin
        mask_q[k_q] <= nbs_ok && (dir_rd_q == want_code);
        k_q         <= k_q + 1'b1;
      end
      if (cmd_i.t_start) begin
        t_r_q   <= scan_r_q;
        t_c_q   <= scan_c_q;
        sum_q   <= '0;
        steps_q <= '0;
      end
      if (cmd_i.t_move) begin
        t_r_q <= mv_r;
        t_c_q <= mv_c;
      end
      if (cmd_i.t_next) begin
        mask_q <= mask_rd_q;
        k_q    <= '0;
        sum_q  <= '0;
      end
      if (cmd_i.sum_add) sum_q <= sum_next;
      if (cmd_i.k_adv)   k_q   <= k_q + 1'b1;
      if (cmd_i.t_step)  steps_q <= steps_q + 1'b1;
    end
  end

  // inside flag of a pending read
  always_ff @(posedge clk_i) begin
    in_inside_q <= in_inside;
  end

  // result word register
  logic             out_valid_q;
  logic             out_kind_q;
  logic [ACC_W-1:0] out_acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_read || cmd_i.out_run) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_read) begin
      out_kind_q <= KIND_READ;
      out_acc_q  <= in_inside_q ? acc_rd_q : '0;
    end else if (cmd_i.out_run) begin
      out_kind_q <= KIND_RUN;
      out_acc_q  <= '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_acc_o   = out_acc_q;

endmodule
